// ----- rtl/core/dllr_pkg.sv -----
// Shared types and constants for the doubly linked record list core.
// Holds field widths, command and status codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package dllr_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 7;
  localparam int SEX_W    = 8;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = (IDX_W > POS_W) ? IDX_W : POS_W;

  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_INS_HEAD  = 3'd0;
  localparam cmd_t CMD_INS_TAIL  = 3'd1;
  localparam cmd_t CMD_INS_AFTER = 3'd2;
  localparam cmd_t CMD_DEL_HEAD  = 3'd3;
  localparam cmd_t CMD_DEL_TAIL  = 3'd4;
  localparam cmd_t CMD_DEL_AT    = 3'd5;
  localparam cmd_t CMD_SEARCH    = 3'd6;
  localparam cmd_t CMD_NOP       = 3'd7;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_BAD_POS = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load_in;     // latch the accepted command
    logic check;       // latch the range/full/empty status
    logic walk_start;  // read the head node
    logic walk_step;   // advance to the next node
    logic hit_latch;   // capture the current node and its links
    logic ld_head_pt;  // insert point is before the head
    logic ins_a;       // write the new node
    logic ins_b;       // patch the neighbors and the head
    logic del;         // unlink the captured node
    logic set_found;   // search hit
    logic load_out;    // move the result to the output register
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t    cmd;
    status_t err_status;
    logic    empty;
    logic    pos_hit;
    logic    next_null;
    logic    key_hit;
    logic    out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/doubly_linked_record_list_core.sv -----
// Top level of the doubly linked record list core.
// Depends on dllr_pkg, dllr_controller and dllr_datapath.
//
// Ordered list of up to CAPACITY (16) records, each a 7-bit roll key and an 8-bit
// sex code, with one status transfer per command transfer. A command is taken
// only when the previous one has finished its work; its result goes into an
// output register so the next command can be taken while the result waits.
// Insert at head (and insert at tail on an empty list) needs no walk; rejected
// commands and the unused code go straight to the result. Delete head, delete
// tail, delete at, insert tail, insert after and search walk the links one node
// per cycle from the head up to the node reached (the last node for tail
// commands, the match or the last node for search), at most CAPACITY nodes. A
// stalled result holds the next result back until the output register is free.
// A new record goes into the lowest free slot. No clearing pass is needed after
// reset.
`default_nettype none

module doubly_linked_record_list_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] command, [9:3] roll_key, [17:10] sex_code, [22:18] position, [23] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [2] found, [7:3] node_count
  output logic [7:0]       m_axis_tdata
);
  import dllr_pkg::*;

  dp_ctrl_t            ctrl;
  dp_stat_t            stat;
  status_t             out_status;
  logic                out_found;
  logic [COUNT_W-1:0]  out_node_count;

  dllr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  dllr_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (s_axis_tdata[2:0]),
    .in_roll_key    (s_axis_tdata[9:3]),
    .in_sex_code    (s_axis_tdata[17:10]),
    .in_position    (s_axis_tdata[22:18]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_node_count (out_node_count)
  );

  assign m_axis_tdata = {out_node_count, out_found, out_status};

endmodule

`default_nettype wire

// ----- rtl/core/dllr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the node record and link stores. No dependencies.
`default_nettype none

module dllr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dllr_datapath.sv -----
// Datapath of the list core: node stores, head, count, free map, walk pointer,
// checks and the output register. Depends on dllr_pkg and dllr_ram.
`default_nettype none

module dllr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dllr_pkg::dp_ctrl_t            ctrl,
  output dllr_pkg::dp_stat_t                 stat,
  input  wire dllr_pkg::cmd_t                in_command,
  input  wire logic [dllr_pkg::KEY_W-1:0]    in_roll_key,
  input  wire logic [dllr_pkg::SEX_W-1:0]    in_sex_code,
  input  wire logic [dllr_pkg::POS_W-1:0]    in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dllr_pkg::status_t                  out_status,
  output logic                               out_found,
  output logic [dllr_pkg::COUNT_W-1:0]       out_node_count
);
  import dllr_pkg::*;

  // latched command
  cmd_t              cmd;
  logic [KEY_W-1:0]  key;
  logic [SEX_W-1:0]  sex;
  logic [POS_W-1:0]  pos;

  // list state
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    count;
  logic [CAPACITY-1:0] free_map;

  // walk and edit registers
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] w;
  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] t;
  status_t          status;
  logic             found;

  logic [SLOT_W-1:0]      free_slot;
  logic [IDX_W-1:0]       free_idx;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_idx;
  logic [KEY_W+SEX_W-1:0] rec_rdata;
  logic [IDX_W-1:0]       next_rdata;
  logic [IDX_W-1:0]       prev_rdata;
  logic                   next_we;
  logic [IDX_W-1:0]       next_widx;
  logic [IDX_W-1:0]       next_wdata;
  logic                   prev_we;
  logic [IDX_W-1:0]       prev_widx;
  logic [IDX_W-1:0]       prev_wdata;

  logic             empty;
  logic             full;
  logic             pos_ok;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] count_c;
  logic [CMP_W-1:0] target_c;
  status_t          err_status;

  function automatic logic valid_idx(input logic [IDX_W-1:0] x);
    return x < NULL_IDX;
  endfunction

  // lowest free slot wins
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end
  assign free_idx = IDX_W'(free_slot);

  // checks on the latched command
  assign pos_c   = CMP_W'(pos);
  assign count_c = CMP_W'(count);
  assign empty   = (count == '0);
  assign full    = (count == NULL_IDX);
  assign pos_ok  = (pos_c != '0) && (pos_c <= count_c);

  always_comb begin
    err_status = ST_DONE;
    case (cmd) inside
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (full) err_status = ST_FULL;
      end
      CMD_INS_AFTER: begin
        if (empty)        err_status = ST_EMPTY;
        else if (!pos_ok) err_status = ST_BAD_POS;
        else if (full)    err_status = ST_FULL;
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_SEARCH: begin
        if (empty) err_status = ST_EMPTY;
      end
      CMD_DEL_AT: begin
        if (empty)        err_status = ST_EMPTY;
        else if (!pos_ok) err_status = ST_BAD_POS;
      end
      default: err_status = ST_DONE;
    endcase
  end

  // delete head walks to position one
  assign target_c = (cmd == CMD_DEL_HEAD) ? CMP_W'(1) : pos_c;

  assign stat.cmd        = cmd;
  assign stat.err_status = err_status;
  assign stat.empty      = empty;
  assign stat.pos_hit    = (CMP_W'(idx) == target_c);
  assign stat.next_null  = !valid_idx(next_rdata);
  assign stat.key_hit    = (rec_rdata[KEY_W-1:0] == key);
  assign stat.out_busy   = out_valid && !out_ready;

  // read port: head on start, follow the link on each step
  assign rd_en  = ctrl.walk_start || ctrl.walk_step;
  assign rd_idx = ctrl.walk_start ? head : next_rdata;

  // link write ports
  always_comb begin
    next_we    = 1'b0;
    next_widx  = free_idx;
    next_wdata = n;
    prev_we    = 1'b0;
    prev_widx  = free_idx;
    prev_wdata = w;
    if (ctrl.ins_a) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (ctrl.ins_b) begin
      next_we    = valid_idx(w);
      next_widx  = w;
      next_wdata = t;
      prev_we    = valid_idx(n);
      prev_widx  = n;
      prev_wdata = t;
    end else if (ctrl.del) begin
      next_we    = valid_idx(p);
      next_widx  = p;
      next_wdata = n;
      prev_we    = valid_idx(n);
      prev_widx  = n;
      prev_wdata = p;
    end
  end

  dllr_ram #(.WIDTH(KEY_W + SEX_W), .DEPTH(CAPACITY)) u_rec_ram (
    .clk   (clk),
    .we    (ctrl.ins_a),
    .waddr (free_slot),
    .wdata ({sex, key}),
    .re    (rd_en),
    .raddr (rd_idx[SLOT_W-1:0]),
    .rdata (rec_rdata)
  );

  dllr_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_widx[SLOT_W-1:0]),
    .wdata (next_wdata),
    .re    (rd_en),
    .raddr (rd_idx[SLOT_W-1:0]),
    .rdata (next_rdata)
  );

  dllr_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_widx[SLOT_W-1:0]),
    .wdata (prev_wdata),
    .re    (rd_en),
    .raddr (rd_idx[SLOT_W-1:0]),
    .rdata (prev_rdata)
  );

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd <= in_command;
      key <= in_roll_key;
      sex <= in_sex_code;
      pos <= in_position;
    end
    if (ctrl.check) begin
      status <= err_status;
    end
    if (ctrl.walk_start) begin
      cur <= head;
      idx <= IDX_W'(1);
    end else if (ctrl.walk_step) begin
      cur <= next_rdata;
      idx <= idx + IDX_W'(1);
    end
    if (ctrl.hit_latch) begin
      w <= cur;
      n <= next_rdata;
      p <= prev_rdata;
    end else if (ctrl.ld_head_pt) begin
      w <= NULL_IDX;
      n <= head;
    end
    if (ctrl.ins_a) begin
      t <= free_idx;
    end
    if (ctrl.load_out) begin
      out_status     <= status;
      out_found      <= found;
      out_node_count <= COUNT_W'(count);
    end
  end

  // list state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NULL_IDX;
      count     <= '0;
      free_map  <= '1;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.load_in) begin
        found <= 1'b0;
      end else if (ctrl.set_found) begin
        found <= 1'b1;
      end
      if (ctrl.ins_b) begin
        if (!valid_idx(w)) head <= t;
        free_map[t[SLOT_W-1:0]] <= 1'b0;
        count <= count + IDX_W'(1);
      end else if (ctrl.del) begin
        if (!valid_idx(p)) head <= n;
        free_map[w[SLOT_W-1:0]] <= 1'b1;
        count <= count - IDX_W'(1);
      end
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dllr_controller.sv -----
// Command sequencer of the list core: checks, link walk, node edits, result hand-off.
// Depends on dllr_pkg; drives dllr_datapath through dp_ctrl_t.
`default_nettype none

module dllr_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output dllr_pkg::dp_ctrl_t      ctrl,
  input  wire dllr_pkg::dp_stat_t stat
);
  import dllr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_INS1  = 3'd4;
  localparam logic [2:0] S_INS2  = 3'd5;
  localparam logic [2:0] S_DEL   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;

  assign in_ready = (state == S_IDLE);

  // what ends the walk depends on the command
  always_comb begin
    case (stat.cmd) inside
      CMD_INS_TAIL, CMD_DEL_TAIL: hit = stat.next_null;
      CMD_SEARCH:                 hit = stat.key_hit;
      default:                    hit = stat.pos_hit;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.check = 1'b1;
        if (stat.err_status != ST_DONE || stat.cmd == CMD_NOP) begin
          state_next = S_RESP;
        end else if (stat.cmd == CMD_INS_HEAD
                     || (stat.cmd == CMD_INS_TAIL && stat.empty)) begin
          ctrl.ld_head_pt = 1'b1;
          state_next      = S_INS1;
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        ctrl.walk_start = 1'b1;
        state_next      = S_WALK;
      end
      S_WALK: begin
        if (hit) begin
          ctrl.hit_latch = 1'b1;
          case (stat.cmd) inside
            CMD_SEARCH: begin
              ctrl.set_found = 1'b1;
              state_next     = S_RESP;
            end
            CMD_INS_TAIL, CMD_INS_AFTER: state_next = S_INS1;
            default:                     state_next = S_DEL;
          endcase
        end else if (stat.cmd == CMD_SEARCH && stat.next_null) begin
          state_next = S_RESP;
        end else begin
          ctrl.walk_step = 1'b1;
        end
      end
      S_INS1: begin
        ctrl.ins_a = 1'b1;
        state_next = S_INS2;
      end
      S_INS2: begin
        ctrl.ins_b = 1'b1;
        state_next = S_RESP;
      end
      S_DEL: begin
        ctrl.del   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the output register frees up
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dllr_checker.sv -----
// Port-level checks for doubly_linked_record_list_core, bound to the top level.
// Depends on dllr_pkg.
`default_nettype none

module dllr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);
  import dllr_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // full is only reported with the list at capacity
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |-> m_axis_tdata[7:3] == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

  // empty is only reported with no records
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_EMPTY |-> m_axis_tdata[7:3] == '0)
    else $error("empty status with records present");

  // a hit implies a successful command on a non-empty list
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ST_DONE && m_axis_tdata[7:3] != '0)
    else $error("found flag without a record");

  // a command transfer is never taken in the cycle right after another
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while busy");

endmodule

bind doubly_linked_record_list_core dllr_checker u_checker (.*);

`default_nettype wire

// ----- tb/list_reply_checker.sv -----
`timescale 1ns / 1ps
// Reply checker for the doubly linked record list core: keeps its own copy of the list,
// predicts the reply to every command transfer and compares it with the reply stream.
// Depends on dllr_pkg.

module list_reply_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  output int               reply_errors,
  output int               replies_owed
);
  import dllr_pkg::*;

  // Packed to match m_axis_tdata: status in the low bits, count on top
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               found;
    status_t            status;
  } list_reply_t;

  typedef logic [IDX_W-1:0] slot_t;

  logic [KEY_W-1:0]   key_mem [CAPACITY];
  logic [SEX_W-1:0]   sex_mem [CAPACITY];
  slot_t              nxt_mem [CAPACITY];
  slot_t              prv_mem [CAPACITY];
  logic [CAPACITY-1:0] free_slots;
  slot_t              head_slot;
  logic [COUNT_W-1:0] rec_total;
  list_reply_t        pending_replies [$];
  int                 mismatch_total = 0;

  // Take the lowest free slot and fill it as an unlinked record
  function automatic slot_t alloc_record(logic [KEY_W-1:0] key, logic [SEX_W-1:0] sex);
    for (int i = 0; i < CAPACITY; i++) begin
      if (free_slots[i]) begin
        free_slots[i] = 1'b0;
        key_mem[i] = key;
        sex_mem[i] = sex;
        nxt_mem[i] = NULL_IDX;
        prv_mem[i] = NULL_IDX;
        rec_total++;
        return slot_t'(i);
      end
    end
    return NULL_IDX;
  endfunction

  function automatic slot_t slot_at(logic [POS_W-1:0] pos);
    slot_t w;
    int c;
    w = head_slot;
    c = 1;
    while (c < pos && w < CAPACITY) begin
      w = nxt_mem[w[SLOT_W-1:0]];
      c++;
    end
    return w;
  endfunction

  function automatic slot_t last_slot();
    slot_t w;
    int steps;
    w = head_slot;
    steps = 0;
    while (w < CAPACITY && nxt_mem[w[SLOT_W-1:0]] < CAPACITY && steps < CAPACITY) begin
      w = nxt_mem[w[SLOT_W-1:0]];
      steps++;
    end
    return w;
  endfunction

  function automatic void link_behind(slot_t w, slot_t t);
    slot_t n;
    n = nxt_mem[w[SLOT_W-1:0]];
    nxt_mem[t[SLOT_W-1:0]] = n;
    prv_mem[t[SLOT_W-1:0]] = w;
    if (n < CAPACITY) prv_mem[n[SLOT_W-1:0]] = t;
    nxt_mem[w[SLOT_W-1:0]] = t;
  endfunction

  function automatic void drop_slot(slot_t d);
    slot_t p;
    slot_t n;
    p = prv_mem[d[SLOT_W-1:0]];
    n = nxt_mem[d[SLOT_W-1:0]];
    if (p < CAPACITY) nxt_mem[p[SLOT_W-1:0]] = n;
    else head_slot = n;
    if (n < CAPACITY) prv_mem[n[SLOT_W-1:0]] = p;
    free_slots[d[SLOT_W-1:0]] = 1'b1;
    if (rec_total > 0) rec_total--;
  endfunction

  always @(posedge clk) begin
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [SEX_W-1:0]   sex;
    logic [POS_W-1:0]   pos;
    logic               empty, full, pos_ok;
    slot_t              w, t;
    list_reply_t        want, got;
    int                 i;
    if (rst) begin
      for (i = 0; i < CAPACITY; i++) begin
        key_mem[i] = '0;
        sex_mem[i] = '0;
        nxt_mem[i] = '0;
        prv_mem[i] = '0;
      end
      free_slots = '1;
      head_slot = NULL_IDX;
      rec_total = '0;
      pending_replies.delete();
    end else begin
      // Compare first: a reply in the same cycle belongs to an earlier command
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_replies.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: reply with none owed: status %0d found %0d count %0d",
                     $realtime, got.status, got.found, got.count);
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.count !== want.count) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display(
                "%0t: mismatch: expected st %0d fd %0d cnt %0d, got st %0d fd %0d cnt %0d",
                $realtime, want.status, want.found, want.count,
                got.status, got.found, got.count);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        cmd = s_axis_tdata[2:0];
        key = s_axis_tdata[9:3];
        sex = s_axis_tdata[17:10];
        pos = s_axis_tdata[22:18];
        want = '0;
        want.status = ST_DONE;
        empty = (rec_total == 0);
        full = (rec_total >= CAPACITY);
        pos_ok = (pos >= 1 && pos <= rec_total);
        case (cmd)
          CMD_INS_HEAD: begin
            if (full) want.status = ST_FULL;
            else begin
              t = alloc_record(key, sex);
              nxt_mem[t[SLOT_W-1:0]] = head_slot;
              if (head_slot < CAPACITY) prv_mem[head_slot[SLOT_W-1:0]] = t;
              head_slot = t;
            end
          end
          CMD_INS_TAIL: begin
            if (full) want.status = ST_FULL;
            else begin
              w = last_slot();
              t = alloc_record(key, sex);
              if (w < CAPACITY) link_behind(w, t);
              else head_slot = t;
            end
          end
          CMD_INS_AFTER: begin
            // empty check, then range, then full
            if (empty) want.status = ST_EMPTY;
            else if (!pos_ok) want.status = ST_BAD_POS;
            else if (full) want.status = ST_FULL;
            else begin
              w = slot_at(pos);
              t = alloc_record(key, sex);
              link_behind(w, t);
            end
          end
          CMD_DEL_HEAD: begin
            if (empty) want.status = ST_EMPTY;
            else drop_slot(head_slot);
          end
          CMD_DEL_TAIL: begin
            if (empty) want.status = ST_EMPTY;
            else drop_slot(last_slot());
          end
          CMD_DEL_AT: begin
            if (empty) want.status = ST_EMPTY;
            else if (!pos_ok) want.status = ST_BAD_POS;
            else drop_slot(slot_at(pos));
          end
          CMD_SEARCH: begin
            if (empty) want.status = ST_EMPTY;
            else begin
              w = head_slot;
              for (i = 0; i < CAPACITY && w < CAPACITY && !want.found; i++) begin
                if (key_mem[w[SLOT_W-1:0]] == key) want.found = 1'b1;
                else w = nxt_mem[w[SLOT_W-1:0]];
              end
            end
          end
          default: ;
        endcase
        want.count = rec_total;
        pending_replies.push_back(want);
      end
    end
    replies_owed <= pending_replies.size();
    reply_errors <= mismatch_total;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the record list core testbench: clock, reset, command stimulus and verdict.
// Depends on dllr_pkg, doubly_linked_record_list_core and list_reply_checker.

module testbench;
  import dllr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CMDS = 750;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  wire logic   s_axis_tready;
  wire logic   m_axis_tvalid;
  wire logic [7:0] m_axis_tdata;

  int   reply_errors;
  int   replies_owed;
  int   quiet_cycles = 0;
  int   ready_hold = 0;
  logic idling_on = 1'b1;

  doubly_linked_record_list_core uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  list_reply_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .reply_errors (reply_errors),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reply side: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!idling_on) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [23:0] pack_cmd(cmd_t cmd, logic [KEY_W-1:0] key,
                                           logic [SEX_W-1:0] sex, logic [POS_W-1:0] pos);
    return {1'b0, pos, sex, key, cmd};
  endfunction

  task automatic send_cmd(input logic [23:0] word);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off new commands until every reply owed has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
  endtask

  initial begin
    cmd_t cmd_order [8];
    int   cuts [3][8];
    int   r, c, mode;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;

    cmd_order = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_DEL_HEAD,
                  CMD_DEL_TAIL, CMD_DEL_AT, CMD_SEARCH, CMD_NOP};
    // Cumulative weights per mode: grow toward full, shrink toward empty, even mix
    cuts = '{'{25, 45, 70, 78, 84, 90, 98, 100},
             '{ 8, 14, 20, 40, 60, 85, 97, 100},
             '{14, 28, 42, 56, 70, 84, 98, 100}};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: every command that needs a record is rejected
    send_cmd(pack_cmd(CMD_INS_AFTER, 7'd10, 8'd1, 5'd1));
    send_cmd(pack_cmd(CMD_DEL_HEAD, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_TAIL, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd1));
    send_cmd(pack_cmd(CMD_SEARCH, 7'd5, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_NOP, 7'd99, 8'd255, 5'd16));
    // Build a short list and probe the position range
    send_cmd(pack_cmd(CMD_INS_HEAD, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_INS_TAIL, 7'd99, 8'd255, 5'd0));
    send_cmd(pack_cmd(CMD_INS_AFTER, 7'd20, 8'd2, 5'd0));
    send_cmd(pack_cmd(CMD_INS_AFTER, 7'd21, 8'd3, 5'd3));
    send_cmd(pack_cmd(CMD_INS_AFTER, 7'd64, 8'd128, 5'd2));
    send_cmd(pack_cmd(CMD_INS_AFTER, 7'd63, 8'd127, 5'd1));
    send_cmd(pack_cmd(CMD_SEARCH, 7'd99, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_SEARCH, 7'd42, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_SEARCH, 7'd64, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd16));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd4));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd1));
    send_cmd(pack_cmd(CMD_NOP, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_TAIL, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_HEAD, 7'd0, 8'd0, 5'd0));
    send_cmd(pack_cmd(CMD_INS_TAIL, 7'd1, 8'h55, 5'd0));
    send_cmd(pack_cmd(CMD_INS_HEAD, 7'd2, 8'haa, 5'd0));
    send_cmd(pack_cmd(CMD_DEL_AT, 7'd0, 8'd0, 5'd2));
    wait_drained();

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i == RANDOM_CMDS / 2) wait_drained();
      // every fourth segment runs without idling, and the tail of the run too
      idling_on <= (i < RANDOM_CMDS - 100) && ((i / 40) % 4 != 3);
      mode = (i / 40) % 3;
      r = $urandom_range(0, 99);
      c = 0;
      while (r >= cuts[mode][c]) c++;
      // small key pool so that searches hit often
      key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 99))
                                         : KEY_W'($urandom_range(0, 15));
      pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 16))
                                         : POS_W'($urandom_range(1, 12));
      send_cmd(pack_cmd(cmd_order[c], key, SEX_W'($urandom_range(0, 255)), pos));
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (reply_errors == 0 && replies_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dllr_pkg.sv
rtl/core/dllr_ram.sv
rtl/core/dllr_datapath.sv
rtl/core/dllr_controller.sv
rtl/core/doubly_linked_record_list_core.sv
rtl/core/dllr_checker.sv
tb/list_reply_checker.sv
tb/testbench.sv
